// ===== src/hse_pkg.sv =====
// Heap sort engine package: microcode word layout, program ROM and compare helper.
`timescale 1ns / 1ps
`default_nettype none
package hse_pkg;

    localparam int unsigned PC_W = 5;
    localparam int unsigned DATA_W = 32;

    // datapath actions, one per control word
    typedef enum logic [4:0] {
        OP_NOP    = 5'd0,
        OP_LOAD   = 5'd1,
        OP_BINIT  = 5'd2,
        OP_BNODE  = 5'd3,
        OP_LATX   = 5'd4,
        OP_RDL    = 5'd5,
        OP_RDR    = 5'd6,
        OP_PICK   = 5'd7,
        OP_MOVE   = 5'd8,
        OP_PLACE  = 5'd9,
        OP_SINIT  = 5'd10,
        OP_RD0    = 5'd11,
        OP_SWAP   = 5'd12,
        OP_SSET   = 5'd13,
        OP_OINIT  = 5'd14,
        OP_ORD    = 5'd15,
        OP_EMIT   = 5'd16,
        OP_FINISH = 5'd17
    } t_op;

    // jump conditions; a taken jump loads the target, else the step counter advances
    typedef enum logic [3:0] {
        C_NEXT       = 4'd0,
        C_ALWAYS     = 4'd1,
        C_NO_START   = 4'd2,
        C_K_ZERO     = 4'd3,
        C_NO_LEFT    = 4'd4,
        C_BEST_ABOVE = 4'd5,
        C_SORTING    = 4'd6,
        C_K_LE1      = 4'd7,
        C_SLOT_BUSY  = 4'd8,
        C_MORE       = 4'd9
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    // program step addresses
    localparam logic [PC_W-1:0] STEP_IDLE   = 5'd0;
    localparam logic [PC_W-1:0] STEP_BINIT  = 5'd1;
    localparam logic [PC_W-1:0] STEP_BCHK   = 5'd2;
    localparam logic [PC_W-1:0] STEP_BNODE  = 5'd3;
    localparam logic [PC_W-1:0] STEP_LATX   = 5'd4;
    localparam logic [PC_W-1:0] STEP_SIFT0  = 5'd5;
    localparam logic [PC_W-1:0] STEP_SIFT1  = 5'd6;
    localparam logic [PC_W-1:0] STEP_SIFT2  = 5'd7;
    localparam logic [PC_W-1:0] STEP_SIFT3  = 5'd8;
    localparam logic [PC_W-1:0] STEP_PLACE  = 5'd9;
    localparam logic [PC_W-1:0] STEP_BLOOP  = 5'd10;
    localparam logic [PC_W-1:0] STEP_SINIT  = 5'd11;
    localparam logic [PC_W-1:0] STEP_SCHK   = 5'd12;
    localparam logic [PC_W-1:0] STEP_SRD0   = 5'd13;
    localparam logic [PC_W-1:0] STEP_SSWAP  = 5'd14;
    localparam logic [PC_W-1:0] STEP_SSET   = 5'd15;
    localparam logic [PC_W-1:0] STEP_OINIT  = 5'd16;
    localparam logic [PC_W-1:0] STEP_ORD    = 5'd17;
    localparam logic [PC_W-1:0] STEP_OEMIT  = 5'd18;
    localparam logic [PC_W-1:0] STEP_OCHK   = 5'd19;
    localparam logic [PC_W-1:0] STEP_FINISH = 5'd20;

    // program ROM
    function automatic t_ctrl micro_rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:   w = '{op: OP_LOAD,   cond: C_NO_START,   target: STEP_IDLE};
            STEP_BINIT:  w = '{op: OP_BINIT,  cond: C_NEXT,       target: STEP_IDLE};
            STEP_BCHK:   w = '{op: OP_NOP,    cond: C_K_ZERO,     target: STEP_SINIT};
            STEP_BNODE:  w = '{op: OP_BNODE,  cond: C_NEXT,       target: STEP_IDLE};
            STEP_LATX:   w = '{op: OP_LATX,   cond: C_NEXT,       target: STEP_IDLE};
            STEP_SIFT0:  w = '{op: OP_RDL,    cond: C_NO_LEFT,    target: STEP_PLACE};
            STEP_SIFT1:  w = '{op: OP_RDR,    cond: C_NEXT,       target: STEP_IDLE};
            STEP_SIFT2:  w = '{op: OP_PICK,   cond: C_NEXT,       target: STEP_IDLE};
            STEP_SIFT3:  w = '{op: OP_MOVE,   cond: C_BEST_ABOVE, target: STEP_SIFT0};
            STEP_PLACE:  w = '{op: OP_PLACE,  cond: C_SORTING,    target: STEP_SCHK};
            STEP_BLOOP:  w = '{op: OP_NOP,    cond: C_ALWAYS,     target: STEP_BCHK};
            STEP_SINIT:  w = '{op: OP_SINIT,  cond: C_NEXT,       target: STEP_IDLE};
            STEP_SCHK:   w = '{op: OP_NOP,    cond: C_K_LE1,      target: STEP_OINIT};
            STEP_SRD0:   w = '{op: OP_RD0,    cond: C_NEXT,       target: STEP_IDLE};
            STEP_SSWAP:  w = '{op: OP_SWAP,   cond: C_NEXT,       target: STEP_IDLE};
            STEP_SSET:   w = '{op: OP_SSET,   cond: C_ALWAYS,     target: STEP_SIFT0};
            STEP_OINIT:  w = '{op: OP_OINIT,  cond: C_NEXT,       target: STEP_IDLE};
            STEP_ORD:    w = '{op: OP_ORD,    cond: C_NEXT,       target: STEP_IDLE};
            STEP_OEMIT:  w = '{op: OP_EMIT,   cond: C_SLOT_BUSY,  target: STEP_OEMIT};
            STEP_OCHK:   w = '{op: OP_NOP,    cond: C_MORE,       target: STEP_ORD};
            STEP_FINISH: w = '{op: OP_FINISH, cond: C_ALWAYS,     target: STEP_IDLE};
            default:     w = '{op: OP_NOP,    cond: C_ALWAYS,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // true if a must sit above b in the heap
    function automatic logic ranks_above(input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b,
                                         input logic min_heap);
        return min_heap ? (a < b) : (a > b);
    endfunction

endpackage
`default_nettype wire

// ===== src/heap_sort_engine_top.sv =====
// Heap sort engine top level: item load, microcoded heap sort and sorted output.
`timescale 1ns / 1ps
`default_nettype none
// Loads signed 32-bit items, one per cycle, into a store of MAX_ITEMS entries; items
// past capacity are dropped and reported through o_overflow on every result of the
// set. The item with i_last set is kept like any other and starts the run: a heap is built,
// heap sort runs, and all stored values come out in order, o_last_res on the final
// one. heap_kind 0 gives ascending order, 1 descending. While the run is busy the
// input stalls. Each level of a sift takes one store read per child, one compare and
// one move; each sift adds its setup (with the root swap during sort), the last child
// check and the final placement, and each result adds a store read, the emit and a
// check. The run time is set by the single read port of the store and the
// step-by-step sequencer.
// Write heap_kind only while idle.
module heap_sort_engine_top #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_cfg_data,
    // input items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [hse_pkg::DATA_W-1:0]   i_value,
    input  wire logic                                i_last,
    // result items
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [hse_pkg::DATA_W-1:0]        o_value_res,
    output logic                                     o_last_res,
    output logic                                     o_overflow
);
    import hse_pkg::*;

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned CH = CW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    // element store
    logic [DATA_W-1:0] mem [MAX_ITEMS];

    logic [PC_W-1:0]          r_pc;
    logic                     r_heap_kind;
    logic                     r_sorting;
    logic                     r_dropped;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_size;
    logic [CW-1:0]            r_k;
    logic [AW-1:0]            r_node;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_lv;
    logic signed [DATA_W-1:0] r_best;
    logic [CH-1:0]            r_bidx;
    logic signed [DATA_W-1:0] r_rd;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_ovf;

    t_ctrl             ctrl;
    logic              in_acc;
    logic              slot_free;
    logic [CH-1:0]     lchild;
    logic [CH-1:0]     rchild;
    logic [CW-1:0]     k_dec;
    logic              best_above;
    logic              right_wins;
    logic              jump;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign ctrl       = micro_rom(r_pc);
    assign in_acc     = i_in_valid && (r_pc == STEP_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign lchild     = CH'({r_node, 1'b1});
    assign rchild     = CH'({r_node, 1'b0}) + CH'(2);
    assign k_dec      = r_k - CW'(1);
    assign best_above = ranks_above(r_best, r_x, r_heap_kind);
    assign right_wins = (rchild < CH'(r_size)) && ranks_above(r_rd, r_lv, r_heap_kind);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_pc != STEP_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_last_res  = r_out_last;
    assign o_overflow  = r_out_ovf;

    // evaluate the jump condition of the current step
    always_comb begin
        case (ctrl.cond)
            C_NEXT:       jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_START:   jump = !(in_acc && i_last);
            C_K_ZERO:     jump = (r_k == '0);
            C_NO_LEFT:    jump = (lchild >= CH'(r_size));
            C_BEST_ABOVE: jump = best_above;
            C_SORTING:    jump = r_sorting;
            C_K_LE1:      jump = (r_k <= CW'(1));
            C_SLOT_BUSY:  jump = !slot_free;
            C_MORE:       jump = (r_k < r_count);
            default:      jump = 1'b1;
        endcase
    end

    // drive the store ports from the control word
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = i_value;
        case (ctrl.op)
            OP_LOAD: begin
                wr_en   = in_acc && (r_count < MAX_CNT);
                wr_addr = r_count[AW-1:0];
                wr_data = i_value;
            end
            OP_BNODE: begin
                rd_en   = 1'b1;
                rd_addr = k_dec[AW-1:0];
            end
            OP_RDL: begin
                rd_en   = 1'b1;
                rd_addr = lchild[AW-1:0];
            end
            OP_RDR: begin
                rd_en   = 1'b1;
                rd_addr = rchild[AW-1:0];
            end
            OP_MOVE: begin
                wr_en   = best_above;
                wr_addr = r_node;
                wr_data = r_best;
            end
            OP_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_node;
                wr_data = r_x;
            end
            OP_RD0: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_SWAP: begin
                // old root goes to the tail while the tail is read out
                rd_en   = 1'b1;
                rd_addr = k_dec[AW-1:0];
                wr_en   = 1'b1;
                wr_addr = k_dec[AW-1:0];
                wr_data = r_rd;
            end
            OP_ORD: begin
                rd_en   = 1'b1;
                rd_addr = r_k[AW-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else if (jump) begin
            r_pc <= ctrl.target;
        end else begin
            r_pc <= r_pc + PC_W'(1);
        end
    end

    // hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_kind <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_heap_kind <= i_cfg_data;
        end
    end

    // control state of the set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_sorting <= 1'b0;
        end else begin
            case (ctrl.op)
                OP_LOAD: begin
                    if (in_acc) begin
                        if (r_count < MAX_CNT) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                OP_SINIT: begin
                    r_sorting <= 1'b1;
                end
                OP_FINISH: begin
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                    r_sorting <= 1'b0;
                end
                default: begin
                    r_sorting <= r_sorting;
                end
            endcase
        end
    end

    // sift datapath registers
    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            OP_BINIT: begin
                r_size <= r_count;
                r_k    <= r_count >> 1;
            end
            OP_BNODE: begin
                r_node <= k_dec[AW-1:0];
                r_k    <= k_dec;
            end
            OP_LATX: begin
                r_x <= r_rd;
            end
            OP_RDR: begin
                r_lv <= r_rd;
            end
            OP_PICK: begin
                r_best <= right_wins ? r_rd : r_lv;
                r_bidx <= right_wins ? rchild : lchild;
            end
            OP_MOVE: begin
                if (best_above) begin
                    r_node <= r_bidx[AW-1:0];
                end
            end
            OP_SINIT: begin
                r_k <= r_size;
            end
            OP_SSET: begin
                r_x    <= r_rd;
                r_node <= '0;
                r_size <= k_dec;
                r_k    <= k_dec;
            end
            OP_OINIT: begin
                r_k <= '0;
            end
            OP_EMIT: begin
                if (slot_free) begin
                    r_k <= r_k + CW'(1);
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // output register: drop on accept, load on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == OP_EMIT && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == OP_EMIT && slot_free) begin
            r_out_value <= r_rd;
            r_out_last  <= ((r_k + CW'(1)) == r_count);
            r_out_ovf   <= r_dropped;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_heap_sort_engine_top.sv =====
// Testbench for heap_sort_engine_top: directed and random sets checked against a sorted-set predictor.
`timescale 1ns / 1ps
module tb_heap_sort_engine_top;
    import hse_pkg::*;

    localparam int unsigned SET_CAPACITY = 64;
    localparam int          RANDOM_ITEMS = 230;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_REPORTS = 40;

    localparam logic KIND_MAX_HEAP = 1'b0;
    localparam logic KIND_MIN_HEAP = 1'b1;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
    localparam word_t WORD_MAX = ~WORD_MIN;

    typedef struct packed {
        word_t value;
        logic  last;
        logic  overflow;
    } sorted_item_t;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    logic  i_cfg_data;
    logic  i_in_valid;
    logic  o_in_stall;
    word_t i_value;
    logic  i_last;
    logic  o_out_valid;
    logic  i_out_stall;
    word_t o_value_res;
    logic  o_last_res;
    logic  o_overflow;

    // predictor state: values of the open set, drop flag and heap kind
    word_t        set_values[$];
    logic         set_dropped;
    logic         kind_model;
    sorted_item_t pending_sorted[$];
    sorted_item_t want;

    int  mismatch_count;
    int  results_seen;
    int  items_loaded;
    int  random_items;
    int  sets_sorted;
    int  overflow_sets;
    int  stall_left;
    bit  gaps_on;
    bit  stalls_on;

    heap_sort_engine_top #(
        .MAX_ITEMS(SET_CAPACITY)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_value_res(o_value_res),
        .o_last_res (o_last_res),
        .o_overflow (o_overflow)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic word_t random_value();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return $urandom_range(0, 1) ? word_t'(0) : word_t'(-1);
            3, 4:    return word_t'($urandom_range(0, 15)) - word_t'(8);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // store the value; on the last item order the set and queue its results
    function automatic void predict_sorted_run(input word_t value, input logic last);
        word_t        ordered[$];
        sorted_item_t item;
        int           pos;
        if (set_values.size() < SET_CAPACITY)
            set_values.push_back(value);
        else
            set_dropped = 1'b1;
        if (!last)
            return;
        // max heap gives ascending order, min heap descending
        foreach (set_values[i]) begin
            pos = 0;
            while (pos < ordered.size() &&
                   (kind_model == KIND_MIN_HEAP ? ordered[pos] >= set_values[i]
                                                : ordered[pos] <= set_values[i]))
                pos++;
            ordered.insert(pos, set_values[i]);
        end
        foreach (ordered[k]) begin
            item.value    = ordered[k];
            item.last     = (k == ordered.size() - 1);
            item.overflow = set_dropped;
            pending_sorted.push_back(item);
        end
        sets_sorted++;
        if (set_dropped)
            overflow_sets++;
        set_values.delete();
        set_dropped = 1'b0;
    endfunction

    // drive one item at the falling edge and hold it until taken
    task automatic load_value(input word_t value, input logic last);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_last     <= last;
        do @(posedge i_clk); while (o_in_stall);
        items_loaded++;
        predict_sorted_run(value, last);
    endtask

    // write heap_kind once the block has emptied and settled
    task automatic set_heap_kind(input logic kind);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= kind;
        do @(posedge i_clk); while (!o_cfg_ready);
        kind_model = kind;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_set(input int size);
        for (int i = 0; i < size; i++) begin
            load_value(random_value(), i == size - 1);
            random_items++;
        end
    endtask

    // output stall: random bursts while enabled
    always @(negedge i_clk) begin
        if (stall_left == 0 && stalls_on)
            stall_left = pick_gap();
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", o_value_res));
            end else begin
                want = pending_sorted.pop_front();
                if (o_value_res !== want.value)
                    report_mismatch($sformatf("value_res %0d, expected %0d",
                                              o_value_res, want.value));
                if (o_last_res !== want.last)
                    report_mismatch($sformatf("last_res %b, expected %b on value %0d",
                                              o_last_res, want.last, want.value));
                if (o_overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b on value %0d",
                                              o_overflow, want.overflow, want.value));
            end
        end
    end

    // extremes of the value range with the reset heap kind
    task automatic test_reset_kind_extremes();
        load_value(WORD_MAX, 1'b0);
        load_value(WORD_MIN, 1'b0);
        load_value(word_t'(0), 1'b0);
        load_value(word_t'(-1), 1'b0);
        load_value(word_t'(1), 1'b1);
    endtask

    // a set of one value
    task automatic test_single_value();
        load_value(WORD_MIN, 1'b1);
    endtask

    // min heap gives descending order; duplicates included
    task automatic test_min_heap();
        set_heap_kind(KIND_MIN_HEAP);
        load_value(word_t'(7), 1'b0);
        load_value(word_t'(-7), 1'b0);
        load_value(word_t'(7), 1'b0);
        load_value(WORD_MIN, 1'b0);
        load_value(WORD_MAX, 1'b0);
        load_value(word_t'(0), 1'b1);
        load_value(WORD_MAX, 1'b1);
    endtask

    // all values equal, then a pair under the max heap again
    task automatic test_equal_values();
        for (int i = 0; i < 4; i++)
            load_value(word_t'(-1), i == 3);
        set_heap_kind(KIND_MAX_HEAP);
        load_value(WORD_MAX, 1'b0);
        load_value(WORD_MIN, 1'b1);
    endtask

    // random sets in phases of random heap kind and idling; one full set, one overflow set
    task automatic test_random_sets();
        int phase;
        int budget;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            set_heap_kind(logic'($urandom_range(0, 1)));
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            if (phase == 1)
                send_random_set(SET_CAPACITY);
            else if (phase == 3)
                send_random_set(SET_CAPACITY + $urandom_range(1, 6));
            budget = random_items + 20;
            while (random_items < budget && random_items < RANDOM_ITEMS) begin
                if ($urandom_range(0, 99) < 85)
                    send_random_set($urandom_range(1, 8));
                else
                    send_random_set($urandom_range(9, 24));
            end
            phase++;
        end
    endtask

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("heap_sort_engine_top regression: fail");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 1'b0;
        i_in_valid     = 1'b0;
        i_value        = '0;
        i_last         = 1'b0;
        i_out_stall    = 1'b0;
        stall_left     = 0;
        gaps_on        = 1'b0;
        stalls_on      = 1'b0;
        set_dropped    = 1'b0;
        kind_model     = KIND_MAX_HEAP;
        mismatch_count = 0;
        results_seen   = 0;
        items_loaded   = 0;
        random_items   = 0;
        sets_sorted    = 0;
        overflow_sets  = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_kind_extremes();
        test_single_value();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_min_heap();
        test_equal_values();
        test_random_sets();

        // hold the input idle and let the last results drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Loaded %0d items in %0d sets (%0d with dropped items); checked %0d results.",
                 items_loaded, sets_sorted, overflow_sets, results_seen);
        $display("Both heap kinds, full and overflowing sets, idle and stalled handshakes.");
        if (mismatch_count == 0)
            $display("heap_sort_engine_top regression: pass");
        else
            $display("heap_sort_engine_top regression: fail");
        $finish;
    end

endmodule
